[sv/s2dc_pkg.sv]
// s2dc_pkg: shared constants and types for the strided 2D convolution block
`default_nettype none
package s2dc_pkg;

    localparam int DEF_KERNEL_SIZE    = 3;
    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_PIXEL_BITS     = 8;
    localparam int DEF_COEF_FRAC_BITS = 12;

    localparam int KERNEL_MAX     = 3;
    localparam int COEF_BITS      = 16;
    localparam int VALUE_BITS     = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 48;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 12;
    localparam int STEP_BITS      = 4;
    localparam int OUT_DEPTH      = 8;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW0    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW1    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_ROW2    = 3'd5;

    localparam logic [WIDTH_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [STEP_BITS-1:0]   RST_STEP         = 4'd1;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
    } t_out_item;

endpackage
`default_nettype wire

[sv/s2dc_ram.sv]
// s2dc_ram: generic single-port-write, registered-read RAM
`default_nettype none
module s2dc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

[sv/strided_2d_convolution.sv]
// strided_2d_convolution: strided KxK convolution over a raster pixel stream
//
//  channel | signals                                        | dir | transfer
//  --------+------------------------------------------------+-----+------------------------
//  pixel   | i_valid, o_ready, i_pixel                      | in  | valid & ready at edge
//  result  | o_valid, i_ready, o_value, o_last              | out | valid & ready at edge
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in | valid & ready at edge
//
//  One pixel per cycle sustained unless o_ready drops. A result is offered on o_valid
//  after line RAM read and window shift, products, row sums, round/saturate of its pixel.
//  The line RAM is read and written once per pixel; a same-column access one item
//  apart is forwarded around the RAM. Synchronous reset clears counters, window and
//  queue; the line RAM is not cleared. Output stalls back up through an 8-item queue;
//  o_ready drops once queued plus in-flight results would fill it.
`default_nettype none
module strided_2d_convolution
    import s2dc_pkg::*;
#(
    parameter int KERNEL_SIZE    = DEF_KERNEL_SIZE,
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS     = DEF_PIXEL_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic        [PIXEL_BITS-1:0]     i_pixel,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic signed      [VALUE_BITS-1:0]     o_value,
    output logic                                  o_last,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic        [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic        [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int CW      = $clog2(MAX_WIDTH + 1);
    localparam int PROD_W  = PIXEL_BITS + COEF_BITS + 1;
    localparam int ROW_W   = PROD_W + 2;
    localparam int ACC_W   = PROD_W + 4;
    localparam int LS_W    = 2 * PIXEL_BITS;
    localparam int PTR_W   = $clog2(OUT_DEPTH);
    localparam int CNT_W   = $clog2(OUT_DEPTH + 1);
    localparam int PEND_W  = 3;

    localparam logic [12:0]     MAXW13   = 13'(MAX_WIDTH);
    localparam logic [ADDR_W-1:0] KM1_C  = ADDR_W'(KERNEL_SIZE - 1);
    localparam logic [HEIGHT_BITS-1:0] KM1_R = HEIGHT_BITS'(KERNEL_SIZE - 1);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN  = -ACC_W'(32768);

    // ---------------- configuration registers ----------------
    logic [WIDTH_BITS-1:0]    r_image_width;
    logic [HEIGHT_BITS-1:0]   r_image_height;
    logic [STEP_BITS-1:0]     r_step;
    logic [CFG_DATA_BITS-1:0] r_coef [KERNEL_MAX];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_step         <= RST_STEP;
            r_coef[0]      <= '0;
            r_coef[1]      <= '0;
            r_coef[2]      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HEIGHT_BITS-1:0];
                REG_STEP:         r_step         <= i_cfg_data[STEP_BITS-1:0];
                REG_COEF_ROW0:    r_coef[0]      <= i_cfg_data;
                REG_COEF_ROW1:    r_coef[1]      <= i_cfg_data;
                REG_COEF_ROW2:    r_coef[2]      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: position counters ----------------
    logic [ADDR_W-1:0]      r_col_count, n_col_count;
    logic [HEIGHT_BITS-1:0] r_row_count, n_row_count;
    logic [STEP_BITS-1:0]   r_col_phase, n_col_phase;
    logic [STEP_BITS-1:0]   r_row_phase, n_row_phase;

    logic [CW-1:0]          w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [STEP_BITS-1:0]   s_eff;
    logic [ADDR_W-1:0]      c_cur;
    logic [HEIGHT_BITS-1:0] r_cur;
    logic                   is_res, is_last, accept;

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = CW'(1);
        end else if ({2'b00, r_image_width} > MAXW13) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_image_width);
        end
        h_eff = (r_image_height == '0) ? HEIGHT_BITS'(1) : r_image_height;
        s_eff = (r_step == '0) ? STEP_BITS'(1) : r_step;

        c_cur = (CW'(r_col_count) < w_eff) ? r_col_count : ADDR_W'(w_eff - CW'(1));
        r_cur = (r_row_count < h_eff) ? r_row_count : h_eff - HEIGHT_BITS'(1);

        is_res  = (r_cur >= KM1_R) && (c_cur >= KM1_C)
                  && (r_row_phase == '0) && (r_col_phase == '0);
        is_last = is_res
                  && (({1'b0, r_cur} + 13'(s_eff)) >= {1'b0, h_eff})
                  && (({1'b0, CW'(c_cur)} + (CW + 1)'(s_eff)) >= {1'b0, w_eff});

        n_col_count = r_col_count;
        n_row_count = r_row_count;
        n_col_phase = r_col_phase;
        n_row_phase = r_row_phase;
        if (c_cur >= KM1_C) begin
            n_col_phase = ({1'b0, r_col_phase} + 5'd1 >= {1'b0, s_eff})
                          ? '0 : r_col_phase + STEP_BITS'(1);
        end
        if (CW'(c_cur) >= w_eff - CW'(1)) begin
            n_col_count = '0;
            n_col_phase = '0;
            if (r_cur >= KM1_R) begin
                n_row_phase = ({1'b0, r_row_phase} + 5'd1 >= {1'b0, s_eff})
                              ? '0 : r_row_phase + STEP_BITS'(1);
            end
            if (r_cur >= h_eff - HEIGHT_BITS'(1)) begin
                n_row_count = '0;
                n_row_phase = '0;
            end else begin
                n_row_count = r_cur + HEIGHT_BITS'(1);
            end
        end else begin
            n_col_count = c_cur + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_col_phase <= '0;
            r_row_phase <= '0;
        end else if (accept) begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
        end
    end

    // ---------------- stage 1: line RAM and window ----------------
    logic                  r_s1_vld, r_s1_res, r_s1_last;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [ADDR_W-1:0]     r_s1_addr;
    logic                  r_s1_fwd;
    logic [LS_W-1:0]       r_s1_fwd_data;
    logic [LS_W-1:0]       ram_rdata, ls_data, wr_data;
    logic [PIXEL_BITS-1:0] src [KERNEL_MAX];
    logic [PIXEL_BITS-1:0] r_window [KERNEL_SIZE][KERNEL_SIZE];

    s2dc_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_vld),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (c_cur),
        .o_rd_data (ram_rdata)
    );

    // low half holds the older row, high half the newer one
    always_comb begin
        ls_data = r_s1_fwd ? r_s1_fwd_data : ram_rdata;
        src[0]  = ls_data[PIXEL_BITS-1:0];
        src[1]  = ls_data[LS_W-1:PIXEL_BITS];
        src[2]  = r_s1_pix;
        wr_data = {r_s1_pix, src[1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_res <= 1'b0;
            r_s1_fwd <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            r_s1_res <= accept && is_res;
            r_s1_fwd <= accept && r_s1_vld && (r_s1_addr == c_cur);
        end
        r_s1_last     <= is_last;
        r_s1_pix      <= i_pixel;
        r_s1_addr     <= c_cur;
        r_s1_fwd_data <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                for (int j = 0; j < KERNEL_SIZE; j++) begin
                    r_window[i][j] <= '0;
                end
            end
        end else if (r_s1_vld) begin
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
                    r_window[i][j] <= r_window[i][j+1];
                end
                r_window[i][KERNEL_SIZE-1] <= src[KERNEL_MAX - KERNEL_SIZE + i];
            end
        end
    end

    // ---------------- stage 2: products ----------------
    logic r_s2_res, r_s2_last;
    logic signed [PROD_W-1:0] prod     [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0] r_s3_prod [KERNEL_SIZE][KERNEL_SIZE];
    logic r_s3_res, r_s3_last;

    always_comb begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                prod[i][j] = PROD_W'($signed({1'b0, r_window[i][j]}))
                             * PROD_W'($signed(r_coef[i][COEF_BITS*j +: COEF_BITS]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_res <= 1'b0;
            r_s3_res <= 1'b0;
        end else begin
            r_s2_res <= r_s1_res;
            r_s3_res <= r_s2_res;
        end
        r_s2_last <= r_s1_last;
        r_s3_last <= r_s2_last;
        r_s3_prod <= prod;
    end

    // ---------------- stage 3: row sums ----------------
    logic signed [ROW_W-1:0] row_sum   [KERNEL_SIZE];
    logic signed [ROW_W-1:0] r_s4_row  [KERNEL_SIZE];
    logic r_s4_res, r_s4_last;

    always_comb begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            row_sum[i] = '0;
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                row_sum[i] = row_sum[i] + ROW_W'(r_s3_prod[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_res <= 1'b0;
        end else begin
            r_s4_res <= r_s3_res;
        end
        r_s4_last <= r_s3_last;
        r_s4_row  <= row_sum;
    end

    // ---------------- stage 4: total, round, saturate ----------------
    logic signed [ACC_W-1:0] total, rounded;
    t_out_item               push_item;

    always_comb begin
        total = '0;
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            total = total + ACC_W'(r_s4_row[i]);
        end
        rounded = (total + RND_HALF) >>> COEF_FRAC_BITS;
        if (rounded > SAT_MAX) begin
            push_item.value = 16'sh7fff;
        end else if (rounded < SAT_MIN) begin
            push_item.value = -16'sh8000;
        end else begin
            push_item.value = VALUE_BITS'(rounded);
        end
        push_item.last = r_s4_last;
    end

    // ---------------- output queue ----------------
    t_out_item          r_fifo [OUT_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [PEND_W-1:0]  pending;
    logic               push, pop;

    assign push    = r_s4_res;
    assign pop     = o_valid && i_ready;
    assign pending = PEND_W'(r_s1_res) + PEND_W'(r_s2_res)
                   + PEND_W'(r_s3_res) + PEND_W'(r_s4_res);
    // hold room for every result still in the pipe
    assign o_ready = ({1'b0, r_cnt} + (CNT_W + 1)'(pending)) < (CNT_W + 1)'(OUT_DEPTH);
    assign accept  = i_valid && o_ready;

    assign o_valid = (r_cnt != '0);
    assign o_value = r_fifo[r_rd_ptr].value;
    assign o_last  = r_fifo[r_rd_ptr].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
        if (push) begin
            r_fifo[r_wr_ptr] <= push_item;
        end
    end

    // ---------------- assertions ----------------
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt < CNT_W'(OUT_DEPTH)))
        else $error("result pushed into a full output queue");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt} + (CNT_W + 1)'(pending)) <= (CNT_W + 1)'(OUT_DEPTH))
        else $error("queued plus in-flight results exceed queue depth");

    a_cnt_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("queue count did not follow a push");

    a_fwd_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> r_s1_vld)
        else $error("line RAM forward without an item in stage 1");

endmodule
`default_nettype wire

[bench/conv_window_checker.sv]
// Window-sum predictor and result scoreboard for the strided 2D convolution block
module conv_window_checker
    import s2dc_pkg::*;
(
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_pix_valid,
    input  wire logic                             i_pix_ready,
    input  wire logic        [DEF_PIXEL_BITS-1:0] i_pix,
    input  wire logic                             i_res_valid,
    input  wire logic                             i_res_ready,
    input  wire logic signed [VALUE_BITS-1:0]     i_res_value,
    input  wire logic                             i_res_last,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             i_cfg_ready,
    input  wire logic        [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic        [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_checked
);

    localparam int LINE_LEN    = DEF_MAX_WIDTH;
    localparam int EDGE        = DEF_KERNEL_SIZE - 1;

    logic [WIDTH_BITS-1:0]     img_width;
    logic [HEIGHT_BITS-1:0]    img_height;
    logic [STEP_BITS-1:0]      stride;
    logic [CFG_DATA_BITS-1:0]  kernel_row [3];

    // two_up holds the row two above the incoming pixel, one_up the row just above
    logic [DEF_PIXEL_BITS-1:0] two_up [LINE_LEN];
    logic [DEF_PIXEL_BITS-1:0] one_up [LINE_LEN];
    logic [DEF_PIXEL_BITS-1:0] win [3][3];
    int unsigned               col_pos, row_pos, col_ph, row_ph;

    t_out_item                 expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic take_pixel(input logic [DEF_PIXEL_BITS-1:0] pix);
        int unsigned                 w, h, s, c, r;
        logic [DEF_PIXEL_BITS-1:0]   up2, up1;
        logic                        hit, final_hit;
        longint                      acc;
        logic signed [COEF_BITS-1:0] cf;
        t_out_item                   item;

        w = img_width;
        h = img_height;
        s = stride;
        if (w < 1) w = 1;
        if (w > LINE_LEN) w = LINE_LEN;
        if (h < 1) h = 1;
        if (s < 1) s = 1;
        // counts left past a shrunken limit end the row or plane here
        c = (col_pos < w) ? col_pos : w - 1;
        r = (row_pos < h) ? row_pos : h - 1;

        up2 = two_up[c];
        up1 = one_up[c];
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = pix;
        two_up[c] = up1;
        one_up[c] = pix;

        hit       = (r >= EDGE) && (c >= EDGE) && (row_ph == 0) && (col_ph == 0);
        final_hit = hit && (r + s >= h) && (c + s >= w);

        if (c >= EDGE) col_ph = (col_ph + 1 >= s) ? 0 : col_ph + 1;
        if (c >= w - 1) begin
            col_pos = 0;
            col_ph  = 0;
            if (r >= EDGE) row_ph = (row_ph + 1 >= s) ? 0 : row_ph + 1;
            if (r >= h - 1) begin
                row_pos = 0;
                row_ph  = 0;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end

        if (hit) begin
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    cf = kernel_row[i][COEF_BITS*j +: COEF_BITS];
                    acc += longint'(win[i][j]) * longint'(cf);
                end
            end
            // round half up, then floor
            acc = (acc + (longint'(1) << (DEF_COEF_FRAC_BITS - 1))) >>> DEF_COEF_FRAC_BITS;
            if (acc > 32767) acc = 32767;
            if (acc < -32768) acc = -32768;
            item.value = acc[VALUE_BITS-1:0];
            item.last  = final_hit;
            expected_results.push_back(item);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            img_width  = RST_IMAGE_WIDTH;
            img_height = RST_IMAGE_HEIGHT;
            stride     = RST_STEP;
            for (int i = 0; i < 3; i++) begin
                kernel_row[i] = '0;
                for (int j = 0; j < 3; j++) win[i][j] = '0;
            end
            for (int k = 0; k < LINE_LEN; k++) begin
                two_up[k] = '0;
                one_up[k] = '0;
            end
            col_pos = 0;
            row_pos = 0;
            col_ph  = 0;
            row_ph  = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  img_width     = i_cfg_data[WIDTH_BITS-1:0];
                    REG_IMAGE_HEIGHT: img_height    = i_cfg_data[HEIGHT_BITS-1:0];
                    REG_STEP:         stride        = i_cfg_data[STEP_BITS-1:0];
                    REG_COEF_ROW0:    kernel_row[0] = i_cfg_data;
                    REG_COEF_ROW1:    kernel_row[1] = i_cfg_data;
                    REG_COEF_ROW2:    kernel_row[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready) take_pixel(i_pix);
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("result with nothing expected: value %0d last %0b",
                                            i_res_value, i_res_last));
                end else begin
                    want = expected_results.pop_front();
                    if (i_res_value !== want.value) begin
                        flag_mismatch($sformatf("result %0d: value %0d, expected %0d",
                                                o_checked, i_res_value, want.value));
                    end
                    if (i_res_last !== want.last) begin
                        flag_mismatch($sformatf("result %0d: last %0b, expected %0b",
                                                o_checked, i_res_last, want.last));
                    end
                    o_checked++;
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[bench/strided_2d_convolution_tb.sv]
// Top-level testbench for strided_2d_convolution: stimulus, flow control and verdict
module strided_2d_convolution_tb;
    import s2dc_pkg::*;

    // register slots past the last defined one; writes there must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam int RESET_CYCLES = 12;
    localparam int TAIL_CYCLES  = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 800;

    typedef enum int {
        KERNEL_RANDOM, KERNEL_GAUSS, KERNEL_BOX, KERNEL_SHARPEN,
        KERNEL_LAPLACE, KERNEL_EXTREME, KERNEL_MAX_POS, KERNEL_MAX_NEG
    } kernel_e;

    typedef enum int {PIX_RANDOM, PIX_FULL, PIX_CHECKER} pixel_pattern_e;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic        [DEF_PIXEL_BITS-1:0] i_pixel;
    logic                             o_valid;
    logic                             i_ready;
    logic signed [VALUE_BITS-1:0]     o_value;
    logic                             o_last;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic        [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic        [CFG_DATA_BITS-1:0]  i_cfg_data;

    int fail_count, pending, checked;
    int pixels_sent   = 0;
    int planes_sent   = 0;
    int setups_loaded = 0;
    int random_items  = 0;
    int plane_pixels  = 1;
    int hold_requests = 0;
    int holds_done    = 0;
    int idle_cycles   = 0;
    bit tx_gaps       = 1'b0;
    bit rx_stalls     = 1'b0;

    always #5 i_clk = ~i_clk;

    strided_2d_convolution dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    conv_window_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_valid),
        .i_pix_ready  (o_ready),
        .i_pix        (i_pixel),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_res_value  (o_value),
        .i_res_last   (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("strided_2d_convolution test failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // unused upper data bits carry noise
    function automatic logic [CFG_DATA_BITS-1:0] noisy(input logic [CFG_DATA_BITS-1:0] v,
                                                       input int bits);
        logic [CFG_DATA_BITS-1:0] low_mask;
        low_mask = (48'd1 << bits) - 48'd1;
        return (rand48() & ~low_mask) | (v & low_mask);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] kernel_row(input kernel_e kind, input int row);
        logic [CFG_DATA_BITS-1:0] bits;
        logic [COEF_BITS-1:0]     cf;
        logic                     center, corner;
        for (int j = 0; j < 3; j++) begin
            center = (row == 1) && (j == 1);
            corner = (row != 1) && (j != 1);
            case (kind)
                KERNEL_GAUSS:   cf = center ? 16'd1024 : corner ? 16'd256 : 16'd512;
                KERNEL_BOX:     cf = 16'd455;
                KERNEL_SHARPEN: cf = center ? 16'd20480 : corner ? 16'd0 : 16'hF000;
                // 8.0 does not fit Q4.12 and wraps to the most negative code
                KERNEL_LAPLACE: cf = center ? 16'h8000 : 16'hF000;
                KERNEL_MAX_POS: cf = 16'h7FFF;
                KERNEL_MAX_NEG: cf = 16'h8000;
                KERNEL_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0:       cf = 16'h7FFF;
                        1:       cf = 16'h8000;
                        2:       cf = 16'h0000;
                        default: cf = 16'hFFFF;
                    endcase
                end
                default:        cf = 16'($urandom);
            endcase
            bits[COEF_BITS*j +: COEF_BITS] = cf;
        end
        return bits;
    endfunction

    // result side: random stalls, plus a long hold-off whenever one is requested
    initial begin
        int n;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_requests) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else if (rx_stalls && $urandom_range(0, 99) < 30) begin
                n = pick_gap();
                i_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic push_pixel(input logic [DEF_PIXEL_BITS-1:0] p);
        int g;
        g = (tx_gaps && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
        if (g > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    task automatic release_pixel();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic push_random(input int count);
        for (int k = 0; k < count; k++) push_pixel(8'($urandom));
        release_pixel();
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every predicted result, then let pixels that give none drain
    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_setup(input int w, input int h, input int s, input kernel_e kind);
        int w_eff, h_eff;
        settle();
        write_reg(REG_IMAGE_WIDTH, noisy(CFG_DATA_BITS'(w), WIDTH_BITS));
        write_reg(REG_IMAGE_HEIGHT, noisy(CFG_DATA_BITS'(h), HEIGHT_BITS));
        write_reg(REG_STEP, noisy(CFG_DATA_BITS'(s), STEP_BITS));
        write_reg(REG_COEF_ROW0, kernel_row(kind, 0));
        write_reg(REG_COEF_ROW1, kernel_row(kind, 1));
        write_reg(REG_COEF_ROW2, kernel_row(kind, 2));
        w_eff = (w < 1) ? 1 : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
        h_eff = (h < 1) ? 1 : h;
        plane_pixels = w_eff * h_eff;
        setups_loaded++;
    endtask

    task automatic stream_planes(input int n, input pixel_pattern_e pat);
        logic [DEF_PIXEL_BITS-1:0] px;
        for (int p = 0; p < n; p++) begin
            for (int k = 0; k < plane_pixels; k++) begin
                case (pat)
                    PIX_FULL:    px = '1;
                    PIX_CHECKER: px = k[0] ? '1 : '0;
                    default:     px = 8'($urandom);
                endcase
                push_pixel(px);
            end
            planes_sent++;
        end
        release_pixel();
    endtask

    initial begin
        kernel_e kind;
        int      w, h, s, n;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_pixel     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_IMAGE_WIDTH;
        i_cfg_data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_SPARE_LO, rand48());
        write_reg(REG_SPARE_HI, rand48());

        // largest positive and negative window sums
        load_setup(3, 3, 1, KERNEL_MAX_POS);
        stream_planes(1, PIX_FULL);
        load_setup(3, 3, 15, KERNEL_MAX_NEG);
        stream_planes(1, PIX_FULL);
        // zero width, height and step behave as one
        load_setup(0, 0, 0, KERNEL_RANDOM);
        stream_planes(1, PIX_RANDOM);
        // plane narrower than the kernel: no window, counters still wrap
        load_setup(2, 3, 1, KERNEL_GAUSS);
        stream_planes(1, PIX_RANDOM);

        // shrink width and stride partway through row 2 (column 7 is past the new width)
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        load_setup(10, 5, 3, KERNEL_RANDOM);
        push_random(27);
        settle();
        write_reg(REG_IMAGE_WIDTH, noisy(CFG_DATA_BITS'(4), WIDTH_BITS));
        write_reg(REG_STEP, noisy(CFG_DATA_BITS'(2), STEP_BITS));
        push_random(9);
        planes_sent++;

        // dense results against a stalled output so the input backs up
        tx_gaps = 1'b0;
        load_setup(16, 8, 1, KERNEL_RANDOM);
        hold_requests++;
        stream_planes(2, PIX_RANDOM);

        while (random_items < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            case ($urandom_range(0, 9))
                0:       s = 0;
                1:       s = 15;
                2, 3:    s = $urandom_range(4, 14);
                default: s = $urandom_range(1, 3);
            endcase
            kind      = kernel_e'($urandom_range(0, 7));
            tx_gaps   = ($urandom_range(0, 4) != 0);
            rx_stalls = ($urandom_range(0, 4) != 0);
            n         = $urandom_range(1, 3);
            load_setup(w, h, s, kind);
            stream_planes(n, ($urandom_range(0, 9) == 0) ? PIX_CHECKER : PIX_RANDOM);
            random_items += n * plane_pixels;
        end

        settle();
        $display("Sent %0d pixels in %0d planes under %0d register setups; %0d results checked.",
                 pixels_sent, planes_sent, setups_loaded, checked);
        $display("Covered output hold-off, mid-row reconfiguration, degenerate sizes, extreme kernels.");
        if (fail_count == 0) begin
            $display("strided_2d_convolution test passed");
        end else begin
            $display("strided_2d_convolution test failed");
        end
        $finish;
    end

endmodule
